// File: hw/rtl/sfd_pkg.sv
package sfd_pkg;

   localparam logic [7:0]  START_BYTE = 8'h55;
   localparam logic [7:0]  TAIL_BYTE  = 8'hAA;
   localparam logic [7:0]  FULL_BYTE  = 8'hFF;
   localparam logic [15:0] LONG_CAP   = 16'd65526;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   // header bytes ahead of the payload: 0x55, addr, len (+ 2 length, 2 complement)
   localparam logic [16:0] SHORT_HEADER = 17'd3;
   localparam logic [16:0] LONG_HEADER  = 17'd7;

   typedef enum logic [2:0] {
      VERDICT_SHORT_OK  = 3'd0,
      VERDICT_LONG_OK   = 3'd1,
      VERDICT_CPL_BAD   = 3'd2,
      VERDICT_OVER_LIM  = 3'd3,
      VERDICT_SUM_BAD   = 3'd4,
      VERDICT_TAIL_BAD  = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [7:0]  frame_address;
      logic [15:0] payload_length;
      logic [15:0] frame_length;
      verdict_type verdict;
   } result_type;

endpackage

// File: hw/rtl/sfd_parser.sv
module sfd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   input  logic              csr_write,
   input  logic [15:0]       csr_data,
   output logic              result_valid,
   output sfd_pkg::result_type result
);
   import sfd_pkg::*;

   typedef enum logic [3:0] {
      PH_HUNT = 4'd0,
      PH_ADDR = 4'd1,
      PH_LEN  = 4'd2,
      PH_LLO  = 4'd3,
      PH_LHI  = 4'd4,
      PH_CLO  = 4'd5,
      PH_CHI  = 4'd6,
      PH_PAY  = 4'd7,
      PH_SUM  = 4'd8,
      PH_TAIL = 4'd9
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  cpl_low_ff, cpl_low_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  addr_ff, addr_in;
   logic        long_ff, long_in;
   logic [15:0] max_payload_ff, max_payload_in;

   logic [15:0] count_inc;
   logic [16:0] pay_end;
   logic [8:0]  cpl_lo_sum;
   logic [8:0]  cpl_hi_sum;

   assign count_inc  = count_ff + 16'd1;
   assign pay_end    = (long_ff ? LONG_HEADER : SHORT_HEADER) + {1'b0, length_ff};
   assign cpl_lo_sum = {1'b0, length_ff[7:0]} + {1'b0, cpl_low_ff};
   assign cpl_hi_sum = {1'b0, length_ff[15:8]} + {1'b0, rx_byte};

   assign max_payload_in = csr_write ? csr_data : max_payload_ff;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      cpl_low_in = cpl_low_ff;
      sum_in     = sum_ff;
      addr_in    = addr_ff;
      long_in    = long_ff;

      result_valid          = 1'b0;
      result.verdict        = VERDICT_SHORT_OK;
      result.frame_length   = count_inc;
      result.payload_length = length_ff;
      result.frame_address  = addr_ff;

      if (step) begin
         if (phase_ff != PH_HUNT) begin
            count_in = count_inc;
         end
         unique case (phase_ff)
            PH_ADDR: begin
               addr_in  = rx_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (rx_byte != 8'd0) begin
                  long_in   = 1'b0;
                  length_in = {8'd0, rx_byte};
                  phase_in  = PH_PAY;
               end else begin
                  long_in  = 1'b1;
                  phase_in = PH_LLO;
               end
            end
            PH_LLO: begin
               length_in = {8'd0, rx_byte};
               phase_in  = PH_LHI;
            end
            PH_LHI: begin
               length_in = {rx_byte, length_ff[7:0]};
               phase_in  = PH_CLO;
            end
            PH_CLO: begin
               cpl_low_in = rx_byte;
               phase_in   = PH_CHI;
            end
            PH_CHI: begin
               // complement first, limit second
               if (cpl_lo_sum != {1'b0, FULL_BYTE} || cpl_hi_sum != {1'b0, FULL_BYTE}) begin
                  result_valid   = 1'b1;
                  result.verdict = VERDICT_CPL_BAD;
                  phase_in       = PH_HUNT;
               end else if (length_ff > max_payload_ff || length_ff > LONG_CAP) begin
                  result_valid   = 1'b1;
                  result.verdict = VERDICT_OVER_LIM;
                  phase_in       = PH_HUNT;
               end else begin
                  phase_in = (length_ff == 16'd0) ? PH_SUM : PH_PAY;
               end
            end
            PH_PAY: begin
               sum_in = sum_ff + rx_byte;
               if ({1'b0, count_inc} >= pay_end) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               if (rx_byte != sum_ff) begin
                  result_valid   = 1'b1;
                  result.verdict = VERDICT_SUM_BAD;
                  phase_in       = PH_HUNT;
               end else begin
                  phase_in = PH_TAIL;
               end
            end
            PH_TAIL: begin
               result_valid = 1'b1;
               phase_in     = PH_HUNT;
               if (rx_byte != TAIL_BYTE) begin
                  result.verdict = VERDICT_TAIL_BAD;
               end else begin
                  result.verdict = long_ff ? VERDICT_LONG_OK : VERDICT_SHORT_OK;
               end
            end
            default: begin
               // hunting, and any code outside the frame phases
               phase_in = PH_HUNT;
               if (rx_byte == START_BYTE) begin
                  count_in   = 16'd1;
                  sum_in     = 8'd0;
                  length_in  = 16'd0;
                  cpl_low_in = 8'd0;
                  long_in    = 1'b0;
                  phase_in   = PH_ADDR;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         count_ff       <= 16'd0;
         length_ff      <= 16'd0;
         cpl_low_ff     <= 8'd0;
         sum_ff         <= 8'd0;
         addr_ff        <= 8'd0;
         long_ff        <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         length_ff      <= length_in;
         cpl_low_ff     <= cpl_low_in;
         sum_ff         <= sum_in;
         addr_ff        <= addr_in;
         long_ff        <= long_in;
         max_payload_ff <= max_payload_in;
      end
   end

endmodule

// File: hw/rtl/sfd_out_buf.sv
module sfd_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  sfd_pkg::result_type wr_data,
   output logic               full,
   output logic               rd_valid,
   input  logic               rd_ready,
   output sfd_pkg::result_type rd_data
);
   import sfd_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hw/rtl/sum_checked_frame_deframer_unit.sv
// Byte-serial deframer for 0x55 ... 0xAA frames with a mod-256 payload sum.
//
// req_*  : one received byte per item. Hunts for 0x55, then parses address,
//          length (short, or long with a 16-bit length and its complement),
//          payload, sum byte and 0xAA tail.
// rsp_*  : at most one verdict item per frame, given at frame end or at the
//          first error; payload bytes are not forwarded.
// csr_*  : writes max_payload, the long-frame payload limit (reset 1024).
//          Write only while the block is idle; csr_ready is always high.
//
// Verdict path: a byte that closes a frame is taken into the input register,
// its verdict is written to the result buffer from there, and rsp_tvalid
// then shows it; a full result buffer holds the byte in the input register.
// Throughput: one byte per cycle while the result buffer is not full, set by
// the parser state register, which takes the next byte in every such cycle.
// Reset: parser back to hunting, result buffer emptied, limit back to 1024.
// Stall: the two-entry result buffer lets bytes flow while a verdict waits;
// req_tready drops once both entries hold unread verdicts and a byte waits
// in the input register.
module sum_checked_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] rx_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [2:0] verdict, [18:3] frame_length, [34:19] payload_length,
   //            [42:35] frame_address, [47:43] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import sfd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       buf_full;
   logic       step;
   logic       res_valid;
   result_type res;
   result_type out_res;

   // input register drains whenever the result buffer has room
   assign step       = in_valid_ff && !buf_full;
   assign req_tready = !in_valid_ff || !buf_full;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   sfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .csr_write    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .result_valid (res_valid),
      .result       (res)
   );

   sfd_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (res_valid),
      .wr_data  (res),
      .full     (buf_full),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (out_res)
   );

   assign rsp_tdata = {5'd0, out_res.frame_address, out_res.payload_length,
                       out_res.frame_length, out_res.verdict};

endmodule

// File: hw/rtl/sfd_checker.sv
module sfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   import sfd_pkg::*;

   // a waiting verdict holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("verdict changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("verdict shown right after reset");

   // short frame: 0x55, addr, len, payload, sum, tail
   a_short_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == VERDICT_SHORT_OK |->
         rsp_tdata[34:27] == 8'd0 && rsp_tdata[26:19] != 8'd0 &&
         rsp_tdata[18:3] == rsp_tdata[34:19] + 16'd5)
      else $error("short frame length inconsistent");

   // long frame: 7 header bytes, payload, sum, tail
   a_long_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == VERDICT_LONG_OK |->
         rsp_tdata[18:3] == rsp_tdata[34:19] + 16'd9)
      else $error("long frame length inconsistent");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd6 && rsp_tdata[2:0] != 3'd7
         && rsp_tdata[47:43] == 5'd0)
      else $error("bad verdict code or padding");

endmodule

bind sum_checked_frame_deframer_unit sfd_checker u_sfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
